FILE: rtl/wpfm_pkg.sv
// Shared constants and controller/datapath interface types for the pulse frequency meter.
package wpfm_pkg;

  // Fixed field widths
  localparam int WIN_W  = 10;  // window register width
  localparam int IDX_W  = 2;   // configuration register index width
  localparam int CHAN_W = 2;   // chan_sel / chan_out width
  localparam int SLOT_W = 7;   // slot_index width
  localparam int PCNT_W = 12;  // pulse_count width
  localparam int Q_W    = 16;  // frequency_hz width
  localparam int N_W    = 7;   // slot count per window, 1..100
  localparam int R_W    = 8;   // divider partial remainder, holds 2*r+1 for r < 128

  // Timing constants
  localparam int SLOT_MS   = 10;
  localparam int MS_PER_S  = 1000;
  localparam int WIN_RESET = 1000;
  localparam int WIN_MAX   = 1000;
  localparam int NUM_REGS  = 4;
  localparam int HZ_SCALE  = MS_PER_S / SLOT_MS;   // sum*1000/(n*10) = sum*100/n
  localparam int N_RESET   = WIN_RESET / SLOT_MS;
  localparam int N_MAX     = WIN_MAX / SLOT_MS;

  // x/10 for 10-bit x as (x*205) >> 11
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;

  // Request codes
  localparam logic REQ_STORE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;     // write zero at the clearing address
    logic store_wr;   // write the incoming pulse count
    logic chan_init;  // set up channel 0
    logic chan_next;  // set up the following channel
    logic acc_step;   // issue the next slot read
    logic mul;        // scale the sum
    logic div_init;   // load the divider
    logic div_step;   // one quotient bit
    logic out_load;   // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing address at the final entry
    logic acc_done;   // all slots of the channel summed
    logic div_done;   // quotient complete
    logic last_chan;  // current channel is the final one
    logic out_free;   // result register can take a value
  } status_t;

endpackage

FILE: rtl/windowed_pulse_frequency_meter.sv
// Store transaction: written in the cycle it is accepted. Compute transaction:
// per channel, n slot reads through the memory's single read port, then scaling,
// a 16-step restoring divider and the result register.
// A waiting result stalls the next result and the compute, but not idle input.
// Reset: synchronous; a clearing pass then writes zero to all CHANNELS*MAX_SLOTS
// entries, one a cycle, with in_ready low; config writes are taken.
module windowed_pulse_frequency_meter #(
  parameter int CHANNELS   = 4,
  parameter int MAX_SLOTS  = 100,
  parameter int COUNT_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [wpfm_pkg::CHAN_W-1:0]   chan_sel,
  input  logic [wpfm_pkg::SLOT_W-1:0]   slot_index,
  input  logic [wpfm_pkg::PCNT_W-1:0]   pulse_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wpfm_pkg::CHAN_W-1:0]   chan_out,
  output logic [wpfm_pkg::Q_W-1:0]      frequency_hz,
  output logic                          last_chan,
  input  logic                          cfg_we,
  input  logic [wpfm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [wpfm_pkg::WIN_W-1:0]    cfg_data
);

  logic [CHANNELS-1:0][wpfm_pkg::N_W-1:0] n_all;
  wpfm_pkg::cmd_t                         cmd;
  wpfm_pkg::status_t                      st;

  // Window registers
  wpfm_win_regs #(
    .CHANNELS (CHANNELS)
  ) u_win_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_all     (n_all)
  );

  // Controller
  wpfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath
  wpfm_datapath #(
    .CHANNELS   (CHANNELS),
    .MAX_SLOTS  (MAX_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .n_all        (n_all),
    .chan_sel     (chan_sel),
    .slot_index   (slot_index),
    .pulse_count  (pulse_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chan_out     (chan_out),
    .frequency_hz (frequency_hz),
    .last_chan    (last_chan)
  );

endmodule

FILE: rtl/wpfm_win_regs.sv
// Window registers: round, clamp and hold the slot count for each channel.
module wpfm_win_regs #(
  parameter int CHANNELS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [wpfm_pkg::IDX_W-1:0]               cfg_index,
  input  logic [wpfm_pkg::WIN_W-1:0]               cfg_data,
  output logic [CHANNELS-1:0][wpfm_pkg::N_W-1:0]   n_all
);

  localparam int PROD_W = wpfm_pkg::WIN_W + 8;

  logic [PROD_W-1:0]        prod;
  logic [wpfm_pkg::N_W-1:0] quot;
  logic [wpfm_pkg::N_W-1:0] n_new;
  logic                     data_ok;

  // Window divided by 10; rounding down and clamping to 10..1000 maps to 1..100 slots
  always_comb begin
    prod    = PROD_W'(cfg_data) * PROD_W'(wpfm_pkg::DIV10_MUL);
    quot    = prod[wpfm_pkg::DIV10_SHIFT +: wpfm_pkg::N_W];
    data_ok = (cfg_data != '0) && (32'(cfg_index) < wpfm_pkg::NUM_REGS);
    if (quot == '0) begin
      n_new = wpfm_pkg::N_W'(1);
    end else if (32'(quot) > wpfm_pkg::N_MAX) begin
      n_new = wpfm_pkg::N_W'(wpfm_pkg::N_MAX);
    end else begin
      n_new = quot;
    end
  end

  // Register bank; a zero write or an unknown index leaves it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        n_all[c] <= wpfm_pkg::N_W'(wpfm_pkg::N_RESET);
      end
    end else if (cfg_we && data_ok) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (32'(cfg_index) == c) begin
          n_all[c] <= n_new;
        end
      end
    end
  end

endmodule

FILE: rtl/wpfm_ctrl.sv
// Controller state machine: clearing pass, store, and per-channel sum/divide sequence.
module wpfm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              req_type,
  output logic              in_ready,
  input  wpfm_pkg::status_t st,
  output wpfm_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIVI  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == wpfm_pkg::REQ_COMPUTE) begin
            cmd.chan_init = 1'b1;
            state_next    = S_ACC;
          end else begin
            cmd.store_wr = 1'b1;
          end
        end
      end
      S_ACC: begin
        if (st.acc_done) begin
          state_next = S_MUL;
        end else begin
          cmd.acc_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.last_chan) begin
            state_next = S_IDLE;
          end else begin
            cmd.chan_next = 1'b1;
            state_next    = S_ACC;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/wpfm_datapath.sv
// Datapath: slot memory, accumulator, scaling, restoring divider and result register.
module wpfm_datapath #(
  parameter int CHANNELS   = 4,
  parameter int MAX_SLOTS  = 100,
  parameter int COUNT_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  wpfm_pkg::cmd_t                           cmd,
  output wpfm_pkg::status_t                        st,
  input  logic [CHANNELS-1:0][wpfm_pkg::N_W-1:0]   n_all,
  input  logic [wpfm_pkg::CHAN_W-1:0]              chan_sel,
  input  logic [wpfm_pkg::SLOT_W-1:0]              slot_index,
  input  logic [wpfm_pkg::PCNT_W-1:0]              pulse_count,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [wpfm_pkg::CHAN_W-1:0]              chan_out,
  output logic [wpfm_pkg::Q_W-1:0]                 frequency_hz,
  output logic                                     last_chan
);

  localparam int CW    = (COUNT_BITS < wpfm_pkg::PCNT_W) ? COUNT_BITS : wpfm_pkg::PCNT_W;
  localparam int SUM_W = CW + wpfm_pkg::N_W;
  localparam int DIV_W = SUM_W + $clog2(wpfm_pkg::HZ_SCALE + 1);
  localparam int HI_W  = DIV_W - wpfm_pkg::Q_W;
  localparam int CMP_W = HI_W + wpfm_pkg::N_W;
  localparam int DEPTH = CHANNELS * MAX_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AX    = AW + 8;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int N_W   = wpfm_pkg::N_W;
  localparam int R_W   = wpfm_pkg::R_W;
  localparam int Q_W   = wpfm_pkg::Q_W;

  // Slot memory
  logic [CW-1:0]    mem [DEPTH];
  logic [CW-1:0]    rd_data;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [CW-1:0]    wr_data;
  logic             wr_en;
  logic [AX-1:0]    st_addr_x;
  logic [AX-1:0]    rd_addr_x;
  logic             st_ok;

  // Sequencing registers
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    base;
  logic [N_W-1:0]   slot_cnt;
  logic [N_W-1:0]   n_cur;
  logic [CH_W-1:0]  chan;
  logic [CH_W-1:0]  n_idx;
  logic [N_W-1:0]   n_sel;
  logic [N_W-1:0]   n_eff;
  logic             rd_pend;
  logic             issue;

  // Arithmetic
  logic [SUM_W-1:0] sum;
  logic [DIV_W-1:0] dividend;
  logic [R_W-1:0]   rem;
  logic [Q_W-1:0]   qd;
  logic [4:0]       div_cnt;
  logic             sat;
  logic             sat_new;
  logic [R_W-1:0]   trial;
  logic             ge;
  logic [CH_W+1:0]  chan_x;

  // Write port: clearing pass or store transaction
  always_comb begin
    st_addr_x = AX'(chan_sel) * AX'(MAX_SLOTS) + AX'(slot_index);
    st_ok     = (32'(chan_sel) < CHANNELS) && (32'(slot_index) < MAX_SLOTS);
    wr_en     = cmd.clr_wr || (cmd.store_wr && st_ok);
    wr_addr   = cmd.clr_wr ? clr_addr : st_addr_x[AW-1:0];
    wr_data   = cmd.clr_wr ? '0 : pulse_count[CW-1:0];
    rd_addr_x = AX'(base) + AX'(slot_cnt);
    rd_addr   = rd_addr_x[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Channel set-up: slot count limited to the store depth
  always_comb begin
    n_idx = cmd.chan_init ? '0 : CH_W'(chan + CH_W'(1));
    n_sel = n_all[n_idx];
    n_eff = (32'(n_sel) > MAX_SLOTS) ? N_W'(MAX_SLOTS) : n_sel;
    issue = cmd.acc_step && (slot_cnt != n_cur);
  end

  // Divider step and saturation check
  always_comb begin
    sat_new = CMP_W'(dividend[DIV_W-1:Q_W]) >= CMP_W'(n_cur);
    trial   = {rem[R_W-2:0], qd[Q_W-1]};
    ge      = trial >= R_W'(n_cur);
    chan_x  = (CH_W+2)'(chan);
  end

  // Sequencing and arithmetic registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      base     <= '0;
      slot_cnt <= '0;
      n_cur    <= N_W'(1);
      chan     <= '0;
      rd_pend  <= 1'b0;
      div_cnt  <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= AW'(clr_addr + AW'(1));
      end
      rd_pend <= issue;
      if (cmd.chan_init || cmd.chan_next) begin
        base     <= cmd.chan_init ? '0 : AW'(AX'(base) + AX'(MAX_SLOTS));
        chan     <= n_idx;
        n_cur    <= n_eff;
        slot_cnt <= '0;
      end else if (issue) begin
        slot_cnt <= N_W'(slot_cnt + N_W'(1));
      end
      if (cmd.div_init) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= 5'(div_cnt + 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chan_init || cmd.chan_next) begin
      sum <= '0;
    end else if (rd_pend) begin
      sum <= SUM_W'(sum + SUM_W'(rd_data));
    end
    if (cmd.mul) begin
      dividend <= DIV_W'(DIV_W'(sum) * DIV_W'(wpfm_pkg::HZ_SCALE));
    end
    if (cmd.div_init) begin
      // quotient overflows 16 bits exactly when the upper part reaches the divisor
      sat <= sat_new;
      rem <= sat_new ? '0 : R_W'(dividend[DIV_W-1:Q_W]);
      qd  <= dividend[Q_W-1:0];
    end else if (cmd.div_step) begin
      rem <= ge ? R_W'(trial - R_W'(n_cur)) : trial;
      qd  <= {qd[Q_W-2:0], ge};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      chan_out     <= chan_x[wpfm_pkg::CHAN_W-1:0];
      frequency_hz <= sat ? '1 : qd;
      last_chan    <= st.last_chan;
    end
  end

  // Status to the controller
  always_comb begin
    st.clr_last  = clr_addr == AW'(DEPTH - 1);
    st.acc_done  = (slot_cnt == n_cur) && !rd_pend;
    st.div_done  = div_cnt == 5'(Q_W);
    st.last_chan = chan == CH_W'(CHANNELS - 1);
    st.out_free  = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_no_overload: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while still full");
  a_wr_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_wr && cmd.store_wr))
    else $error("store transaction during clearing pass");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_cnt <= n_cur)
    else $error("slot counter beyond window");
  a_rd_origin: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(cmd.acc_step))
    else $error("slot read pending without an issue");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_cnt < 5'(Q_W)))
    else $error("divider stepped past the quotient width");
`endif

endmodule

FILE: test/windowed_pulse_frequency_meter_checker.sv
// Result checker for the pulse frequency meter: tracks slot counts and windows, predicts and compares.
module windowed_pulse_frequency_meter_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        req_type,
  input  logic [wpfm_pkg::CHAN_W-1:0] chan_sel,
  input  logic [wpfm_pkg::SLOT_W-1:0] slot_index,
  input  logic [wpfm_pkg::PCNT_W-1:0] pulse_count,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [wpfm_pkg::CHAN_W-1:0] chan_out,
  input  logic [wpfm_pkg::Q_W-1:0]    frequency_hz,
  input  logic                        last_chan,
  input  logic                        cfg_we,
  input  logic [wpfm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [wpfm_pkg::WIN_W-1:0]  cfg_data,
  output int                          mismatches,
  output int                          outstanding,
  output int                          stores_seen,
  output int                          computes_seen,
  output int                          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CHANNELS      = 4;
  localparam int SLOTS_PER_CHANNEL = 100;
  localparam longint unsigned HZ_CEILING = (64'd1 << wpfm_pkg::Q_W) - 1;

  typedef struct packed {
    logic [wpfm_pkg::CHAN_W-1:0] chan;
    logic [wpfm_pkg::Q_W-1:0]    freq;
    logic                        last;
  } freq_result_t;

  logic [wpfm_pkg::PCNT_W-1:0] slot_counts [NUM_CHANNELS][SLOTS_PER_CHANNEL];
  int unsigned                 win_ms [NUM_CHANNELS];
  freq_result_t                freq_expect_q [$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    stores_seen   = 0;
    computes_seen = 0;
    results_seen  = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t: frequency meter mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Window register rules: zero ignored, round down to 10 ms, clamp to 10..1000
  function automatic int unsigned next_window(input logic [wpfm_pkg::WIN_W-1:0] data,
                                              input int unsigned current);
    int unsigned w;
    w = (int'(data) / wpfm_pkg::SLOT_MS) * wpfm_pkg::SLOT_MS;
    if (data == '0) return current;
    if (w < wpfm_pkg::SLOT_MS) w = wpfm_pkg::SLOT_MS;
    if (w > wpfm_pkg::WIN_MAX) w = wpfm_pkg::WIN_MAX;
    return w;
  endfunction

  // Mean pulse rate over the channel's window, saturated to the output width
  function automatic logic [wpfm_pkg::Q_W-1:0] window_frequency(input int ch);
    longint unsigned total;
    longint unsigned hz;
    int unsigned n;
    total = 0;
    n = win_ms[ch] / wpfm_pkg::SLOT_MS;
    if (n < 1) n = 1;
    if (n > SLOTS_PER_CHANNEL) n = SLOTS_PER_CHANNEL;
    for (int i = 0; i < n; i++) total += slot_counts[ch][i];
    hz = (total * wpfm_pkg::MS_PER_S) / (n * wpfm_pkg::SLOT_MS);
    if (hz > HZ_CEILING) hz = HZ_CEILING;
    return hz[wpfm_pkg::Q_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    freq_result_t want;
    int delta;
    delta = 0;
    if (rst) begin
      foreach (slot_counts[c, s]) slot_counts[c][s] = '0;
      foreach (win_ms[c]) win_ms[c] = wpfm_pkg::WIN_RESET;
      freq_expect_q.delete();
      outstanding <= 0;
    end else begin
      // register writes
      if (cfg_we && int'(cfg_index) < wpfm_pkg::NUM_REGS &&
          int'(cfg_index) < NUM_CHANNELS) begin
        win_ms[cfg_index] = next_window(cfg_data, win_ms[cfg_index]);
      end

      // result transactions
      if (out_valid && out_ready) begin
        results_seen++;
        if (freq_expect_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: chan %0d freq %0d last %0b",
                                  chan_out, frequency_hz, last_chan));
        end else begin
          want = freq_expect_q.pop_front();
          delta--;
          if (chan_out !== want.chan)
            flag_mismatch($sformatf("chan_out %0d, expected %0d", chan_out, want.chan));
          if (frequency_hz !== want.freq)
            flag_mismatch($sformatf("chan %0d frequency_hz %0d, expected %0d",
                                    want.chan, frequency_hz, want.freq));
          if (last_chan !== want.last)
            flag_mismatch($sformatf("chan %0d last_chan %0b, expected %0b",
                                    want.chan, last_chan, want.last));
        end
      end

      // request transactions
      if (in_valid && in_ready) begin
        if (req_type == wpfm_pkg::REQ_STORE) begin
          stores_seen++;
          // out-of-range slots are dropped
          if (int'(chan_sel) < NUM_CHANNELS && int'(slot_index) < SLOTS_PER_CHANNEL)
            slot_counts[chan_sel][slot_index] = pulse_count;
        end else begin
          computes_seen++;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            want.chan = wpfm_pkg::CHAN_W'(c);
            want.freq = window_frequency(c);
            want.last = (c == NUM_CHANNELS - 1);
            freq_expect_q.push_back(want);
            delta++;
          end
        end
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

FILE: test/windowed_pulse_frequency_meter_tb.sv
// Testbench top for the pulse frequency meter: clock, reset, stimulus and verdict.
module windowed_pulse_frequency_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic                        req_type    = wpfm_pkg::REQ_STORE;
  logic [wpfm_pkg::CHAN_W-1:0] chan_sel    = '0;
  logic [wpfm_pkg::SLOT_W-1:0] slot_index  = '0;
  logic [wpfm_pkg::PCNT_W-1:0] pulse_count = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic [wpfm_pkg::CHAN_W-1:0] chan_out;
  logic [wpfm_pkg::Q_W-1:0]    frequency_hz;
  logic                        last_chan;
  logic                        cfg_we      = 1'b0;
  logic [wpfm_pkg::IDX_W-1:0]  cfg_index   = '0;
  logic [wpfm_pkg::WIN_W-1:0]  cfg_data    = '0;

  int mismatches, outstanding, stores_seen, computes_seen, results_seen;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  windowed_pulse_frequency_meter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .chan_sel(chan_sel), .slot_index(slot_index),
    .pulse_count(pulse_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .chan_out(chan_out), .frequency_hz(frequency_hz), .last_chan(last_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  windowed_pulse_frequency_meter_checker freq_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .chan_sel(chan_sel), .slot_index(slot_index),
    .pulse_count(pulse_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .chan_out(chan_out), .frequency_hz(frequency_hz), .last_chan(last_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .stores_seen(stores_seen), .computes_seen(computes_seen),
    .results_seen(results_seen)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // One request transaction, with optional idle cycles in front
  task automatic send_request(input logic rq, input logic [wpfm_pkg::CHAN_W-1:0] ch,
                              input logic [wpfm_pkg::SLOT_W-1:0] slot,
                              input logic [wpfm_pkg::PCNT_W-1:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    chan_sel    <= ch;
    slot_index  <= slot;
    pulse_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the input until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Quiet point for register writes
  task automatic settle();
    drain_results();
    repeat (30) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch
  task automatic write_window(input logic [wpfm_pkg::IDX_W-1:0] idx,
                              input logic [wpfm_pkg::WIN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_random_windows();
    logic [wpfm_pkg::WIN_W-1:0] w;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(3))
        0:       w = wpfm_pkg::WIN_W'($urandom_range(19));        // zero, sub-slot, shortest
        1:       w = wpfm_pkg::WIN_W'($urandom_range(1023, 990)); // just under full, full window and clamped
        2:       w = wpfm_pkg::WIN_W'($urandom_range(200, 10));
        default: w = wpfm_pkg::WIN_W'($urandom_range(1023));
      endcase
      write_window(wpfm_pkg::IDX_W'(c), w);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly stores into the low slots that windows cover, some computes, a few dropped slots
  task automatic random_request();
    logic                        rq;
    logic [wpfm_pkg::SLOT_W-1:0] slot;
    logic [wpfm_pkg::PCNT_W-1:0] cnt;
    int                          pick;
    rq   = ($urandom_range(99) < 25) ? wpfm_pkg::REQ_COMPUTE : wpfm_pkg::REQ_STORE;
    pick = $urandom_range(99);
    if (pick < 50)      slot = wpfm_pkg::SLOT_W'($urandom_range(9));
    else if (pick < 88) slot = wpfm_pkg::SLOT_W'($urandom_range(99));
    else                slot = wpfm_pkg::SLOT_W'($urandom_range(127, 100));
    pick = $urandom_range(99);
    if (pick < 15)      cnt = '1;
    else if (pick < 25) cnt = '0;
    else if (pick < 45) cnt = wpfm_pkg::PCNT_W'($urandom_range(700, 600)); // near saturation
    else                cnt = wpfm_pkg::PCNT_W'($urandom_range(4095));
    send_request(rq, wpfm_pkg::CHAN_W'($urandom_range(3)), slot, cnt);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
    settle();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    program_random_windows();
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain_results();
      random_request();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset windows: store must read back as all zero
    send_request(wpfm_pkg::REQ_COMPUTE, '0, '0, '0);
    send_request(wpfm_pkg::REQ_STORE, 2'd0, 7'd0, 12'hFFF);
    send_request(wpfm_pkg::REQ_STORE, 2'd0, 7'd99, 12'hFFF);
    send_request(wpfm_pkg::REQ_STORE, 2'd1, 7'd127, 12'hFFF);   // slot beyond the store
    send_request(wpfm_pkg::REQ_STORE, 2'd2, 7'd100, 12'd1);     // first slot out of range
    send_request(wpfm_pkg::REQ_STORE, 2'd3, 7'd50, 12'hAAA);
    send_request(wpfm_pkg::REQ_STORE, 2'd1, 7'd0, 12'h555);
    send_request(wpfm_pkg::REQ_STORE, 2'd2, 7'd3, 12'hFFF);
    send_request(wpfm_pkg::REQ_COMPUTE, 2'd3, 7'd127, 12'hFFF); // unused fields set

    // zero write ignored, rounding and both clamps
    settle();
    write_window(2'd0, 10'd5);
    write_window(2'd1, 10'd0);
    write_window(2'd1, 10'd15);
    write_window(2'd2, 10'd1023);
    write_window(2'd3, 10'd995);
    cfg_we <= 1'b0;
    send_request(wpfm_pkg::REQ_COMPUTE, '0, '0, '0);
    send_request(wpfm_pkg::REQ_STORE, 2'd0, 7'd0, 12'd654);     // just under saturation
    send_request(wpfm_pkg::REQ_STORE, 2'd1, 7'd0, 12'd656);     // just over
    send_request(wpfm_pkg::REQ_STORE, 2'd3, 7'd99, 12'hFFF);    // outside a 990 ms window
    send_request(wpfm_pkg::REQ_STORE, 2'd3, 7'd98, 12'd1);
    send_request(wpfm_pkg::REQ_COMPUTE, '0, '0, '0);

    settle();
    write_window(2'd0, 10'd1000);
    write_window(2'd2, 10'd10);
    cfg_we <= 1'b0;
    send_request(wpfm_pkg::REQ_STORE, 2'd2, 7'd0, 12'd0);
    send_request(wpfm_pkg::REQ_COMPUTE, '0, '0, '0);

    // random traffic under three handshake pressure profiles
    run_phase(7, 70, 93);
    run_phase(70, 7, 93);
    run_phase(0, 0, 94);

    drain_results();
    repeat (50) @(posedge clk);
    $display("Covered %0d store and %0d compute transactions, %0d results checked,",
             stores_seen, computes_seen, results_seen);
    $display("with windows from 10 to 1000 ms and idling on both sides.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("windowed_pulse_frequency_meter test passed");
    end else begin
      $display("windowed_pulse_frequency_meter test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("windowed_pulse_frequency_meter test failed");
    $finish;
  end

endmodule

FILE: windowed_pulse_frequency_meter.f
rtl/wpfm_pkg.sv
rtl/wpfm_win_regs.sv
rtl/wpfm_ctrl.sv
rtl/wpfm_datapath.sv
rtl/windowed_pulse_frequency_meter.sv
test/windowed_pulse_frequency_meter_checker.sv
test/windowed_pulse_frequency_meter_tb.sv
